/* hdl/sed_pkg.sv */
// Shared types and constants for the SSID escape decoder.
// No dependencies; every other file in hdl/ depends on this package.
package sed_pkg;

  localparam int CHAR_W = 8;
  localparam int CNT_W  = 6;
  localparam int BUF_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CNT_W-1:0] MAX_BYTES       = 6'd32;
  localparam logic [BUF_W-1:0] BUF_SIZE_RESET  = 11'd33;
  localparam logic             REG_BUFFER_SIZE = 1'b0;

  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [CHAR_W-1:0] CH_N         = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_R         = 8'h72;
  localparam logic [CHAR_W-1:0] CH_T         = 8'h74;
  localparam logic [CHAR_W-1:0] CH_E         = 8'h65;
  localparam logic [CHAR_W-1:0] CH_X         = 8'h78;
  localparam logic [CHAR_W-1:0] BYTE_LF      = 8'h0a;
  localparam logic [CHAR_W-1:0] BYTE_CR      = 8'h0d;
  localparam logic [CHAR_W-1:0] BYTE_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] BYTE_ESC     = 8'h1b;

  typedef enum logic [2:0] {
    PH_NORMAL   = 3'd0,
    PH_ESC      = 3'd1,
    PH_HEX_HIGH = 3'd2,
    PH_HEX_LOW  = 3'd3,
    PH_ERROR    = 3'd4
  } sed_phase_t;

  // One request after classification, as it sits in the queue.
  typedef struct packed {
    logic              end_mark;
    logic [CHAR_W-1:0] ch;
    logic              is_bs;
    logic              esc_ok;
    logic [CHAR_W-1:0] esc_byte;
    logic              is_x;
    logic              hex_ok;
    logic [3:0]        hex_val;
  } sed_cls_t;

  typedef struct packed {
    logic push;
    logic pop;
  } sed_qctl_t;

endpackage

/* hdl/sed_if.sv */
// Valid/ready channel interfaces for the SSID escape decoder.
// Depends on sed_pkg for field widths.
interface sed_in_if;
  logic                      valid;
  logic                      ready;
  logic [sed_pkg::CHAR_W-1:0] in_char;
  logic                      end_mark;

  modport source (output valid, output in_char, output end_mark, input ready);
  modport sink   (input valid, input in_char, input end_mark, output ready);
endinterface

interface sed_out_if;
  logic                      valid;
  logic                      ready;
  logic [sed_pkg::CHAR_W-1:0] out_byte;
  logic                      byte_valid;
  logic                      done_res;
  logic                      status;
  logic [sed_pkg::CNT_W-1:0]  decoded_length;

  modport source (output valid, output out_byte, output byte_valid, output done_res,
                  output status, output decoded_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                  input status, input decoded_length, output ready);
endinterface

/* hdl/sed_front.sv */
// Front end: accepts input requests and classifies each character.
// Depends on sed_pkg and sed_in_if.
module sed_front (
  sed_in_if.sink            req_in,
  input  logic              q_full,
  output logic              push,
  output sed_pkg::sed_cls_t push_data
);
  import sed_pkg::*;

  always_comb begin
    req_in.ready = !q_full;
    push         = req_in.valid && !q_full;

    push_data          = '0;
    push_data.end_mark = req_in.end_mark;
    push_data.ch       = req_in.in_char;
    push_data.is_bs    = (req_in.in_char == CH_BACKSLASH);
    push_data.is_x     = (req_in.in_char == CH_X);

    push_data.esc_ok = 1'b1;
    unique case (req_in.in_char)
      CH_BACKSLASH: push_data.esc_byte = CH_BACKSLASH;
      CH_QUOTE:     push_data.esc_byte = CH_QUOTE;
      CH_N:         push_data.esc_byte = BYTE_LF;
      CH_R:         push_data.esc_byte = BYTE_CR;
      CH_T:         push_data.esc_byte = BYTE_TAB;
      CH_E:         push_data.esc_byte = BYTE_ESC;
      default: begin
        push_data.esc_ok   = 1'b0;
        push_data.esc_byte = '0;
      end
    endcase

    // Hex digit, either case.
    if (req_in.in_char >= 8'h30 && req_in.in_char <= 8'h39) begin
      push_data.hex_ok  = 1'b1;
      push_data.hex_val = req_in.in_char[3:0];
    end else if ((req_in.in_char >= 8'h61 && req_in.in_char <= 8'h66) ||
                 (req_in.in_char >= 8'h41 && req_in.in_char <= 8'h46)) begin
      push_data.hex_ok  = 1'b1;
      push_data.hex_val = req_in.in_char[3:0] + 4'd9;
    end else begin
      push_data.hex_ok  = 1'b0;
      push_data.hex_val = '0;
    end
  end

endmodule

/* hdl/sed_queue.sv */
// Two-entry queue of classified requests between front and back.
// Depends on sed_pkg.
module sed_queue (
  input  logic              clk,
  input  logic              rst,
  input  sed_pkg::sed_qctl_t ctl,
  input  sed_pkg::sed_cls_t  wr_data,
  output sed_pkg::sed_cls_t  rd_data,
  output logic              full,
  output logic              not_empty
);
  import sed_pkg::*;

  sed_cls_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (ctl.push) wr_ptr <= !wr_ptr;
      if (ctl.pop)  rd_ptr <= !rd_ptr;
      unique case ({ctl.push, ctl.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/sed_back.sv */
// Back end: escape parser state machine, length and error checks, result register.
// Depends on sed_pkg and sed_out_if.
module sed_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [sed_pkg::BUF_W-1:0] buffer_size,
  input  logic                      head_valid,
  input  sed_pkg::sed_cls_t         head,
  output logic                      pop,
  sed_out_if.source                 res_out
);
  import sed_pkg::*;

  sed_phase_t        phase, phase_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;

  logic              res_valid;
  logic              res_load;
  logic [CHAR_W-1:0] res_byte, res_byte_next;
  logic              res_bv, res_bv_next;
  logic              res_done, res_done_next;
  logic              res_status, res_status_next;
  logic [CNT_W-1:0]  res_len, res_len_next;

  logic              want_emit;
  logic [CHAR_W-1:0] emit_val;
  logic [BUF_W-1:0]  count_ext;
  logic              ok;

  assign count_ext = {{(BUF_W-CNT_W){1'b0}}, byte_count};
  assign pop       = head_valid && (!res_valid || res_out.ready);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    byte_count_next  = byte_count;
    res_load         = 1'b0;
    res_byte_next    = '0;
    res_bv_next      = 1'b0;
    res_done_next    = 1'b0;
    res_status_next  = 1'b0;
    res_len_next     = '0;
    want_emit        = 1'b0;
    emit_val         = '0;
    ok               = 1'b0;

    if (pop) begin
      if (head.end_mark) begin
        ok = (phase == PH_NORMAL) && (byte_count != '0) &&
             (byte_count <= MAX_BYTES) && (count_ext < buffer_size);
        res_load         = 1'b1;
        res_done_next    = 1'b1;
        res_status_next  = !ok;
        res_len_next     = ok ? byte_count : '0;
        phase_next       = PH_NORMAL;
        high_nibble_next = '0;
        byte_count_next  = '0;
      end else begin
        unique case (phase)
          PH_NORMAL: begin
            if (head.is_bs) begin
              phase_next = PH_ESC;
            end else begin
              want_emit = 1'b1;
              emit_val  = head.ch;
            end
          end
          PH_ESC: begin
            if (head.esc_ok) begin
              want_emit = 1'b1;
              emit_val  = head.esc_byte;
            end else if (head.is_x) begin
              phase_next = PH_HEX_HIGH;
            end else begin
              phase_next = PH_ERROR;
            end
          end
          PH_HEX_HIGH: begin
            if (head.hex_ok) begin
              high_nibble_next = head.hex_val;
              phase_next       = PH_HEX_LOW;
            end else begin
              phase_next = PH_ERROR;
            end
          end
          PH_HEX_LOW: begin
            if (head.hex_ok) begin
              want_emit = 1'b1;
              emit_val  = {high_nibble, head.hex_val};
            end else begin
              phase_next = PH_ERROR;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase

        if (want_emit) begin
          // Drop the byte and latch an error on zero or length overflow.
          if (emit_val == '0 || byte_count >= MAX_BYTES ||
              count_ext + 11'd1 >= buffer_size) begin
            phase_next = PH_ERROR;
          end else begin
            byte_count_next = byte_count + 6'd1;
            phase_next      = PH_NORMAL;
            res_load        = 1'b1;
            res_byte_next   = emit_val;
            res_bv_next     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      high_nibble <= '0;
      byte_count  <= '0;
      res_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      byte_count  <= byte_count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_byte   <= res_byte_next;
      res_bv     <= res_bv_next;
      res_done   <= res_done_next;
      res_status <= res_status_next;
      res_len    <= res_len_next;
    end
  end

  assign res_out.valid          = res_valid;
  assign res_out.out_byte       = res_byte;
  assign res_out.byte_valid     = res_bv;
  assign res_out.done_res       = res_done;
  assign res_out.status         = res_status;
  assign res_out.decoded_length = res_len;

endmodule

/* hdl/ssid_escape_decoder_core.sv */
// Top level of the SSID escape decoder: front classifier, queue, back parser, APB register.
// Depends on sed_pkg, sed_if, sed_front, sed_queue and sed_back.
//
//   channel   dir   handshake       payload
//   req_in    in    valid/ready     in_char[7:0], end_mark
//   res_out   out   valid/ready     out_byte[7:0], byte_valid, done_res, status,
//                                   decoded_length[5:0]
//   apb       in    psel/penable    paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// One request per cycle sustained while the sink is ready; a result appears in the cycle after the back
// parser pops its request, the parser state loop deciding each item.
// A two-entry queue parts the front from the parser, and the result register
// parts the parser from the sink; a stalled sink stops pops, then fills the queue.
// Reset (rst, synchronous) empties the queue, clears the parser, sets buffer_size to 33.
module ssid_escape_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  sed_in_if.sink                     req_in,
  sed_out_if.source                  res_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sed_pkg::ADDR_W-1:0] paddr,
  input  logic [sed_pkg::DATA_W-1:0] pwdata,
  output logic [sed_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import sed_pkg::*;

  logic [BUF_W-1:0] buffer_size;
  sed_qctl_t        qctl;
  sed_cls_t         push_data;
  sed_cls_t         head;
  logic             q_full;
  logic             q_not_empty;
  logic             push;
  logic             pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BUFFER_SIZE) begin
      buffer_size <= pwdata[BUF_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BUFFER_SIZE) ?
                  {{(DATA_W-BUF_W){1'b0}}, buffer_size} : '0;

  assign qctl.push = push;
  assign qctl.pop  = pop;

  sed_front u_front (
    .req_in    (req_in),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  sed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (qctl),
    .wr_data   (push_data),
    .rd_data   (head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  sed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .buffer_size (buffer_size),
    .head_valid  (q_not_empty),
    .head        (head),
    .pop         (pop),
    .res_out     (res_out)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for ssid_escape_decoder_core: drives escaped SSID strings,
// predicts every decoded byte and end status, and checks results field by field.
// Depends on sed_pkg, sed_if and the RTL under hdl/.
module testbench;
  import sed_pkg::*;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] out_byte;
    logic              byte_valid;
    logic              done_res;
    logic              status;
    logic [CNT_W-1:0]  decoded_length;
  } ssid_res_t;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  class ssid_checker;
    ssid_res_t pending_results[$];
    int        errors;

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_request(bit has_res, ssid_res_t r);
      if (has_res) pending_results.push_back(r);
    endfunction

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(ssid_res_t got);
      ssid_res_t want;
      if (pending_results.size() == 0) begin
        report("result with no request waiting for one");
        return;
      end
      want = pending_results.pop_front();
      check_field("out_byte", got.out_byte, want.out_byte);
      check_field("byte_valid", got.byte_valid, want.byte_valid);
      check_field("done_res", got.done_res, want.done_res);
      check_field("status", got.status, want.status);
      check_field("decoded_length", got.decoded_length, want.decoded_length);
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sed_in_if  req_if ();
  sed_out_if res_if ();

  ssid_escape_decoder_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .req_in  (req_if),
    .res_out (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ssid_checker chk = new();

  // decoder state as the block should hold it
  logic [BUF_W-1:0] buf_size_q = BUF_SIZE_RESET;
  sed_phase_t       phase_q    = PH_NORMAL;
  logic [3:0]       nibble_q   = '0;
  logic [CNT_W-1:0] count_q    = '0;

  bit calm;
  int items_sent;

  logic [CHAR_W-1:0] esc_letters[6] = '{CH_BACKSLASH, CH_QUOTE, CH_N, CH_R, CH_T, CH_E};
  logic [BUF_W-1:0]  buf_sizes[10]  = '{11'd33, 11'd1, 11'd0, 11'd2, 11'd2047,
                                       11'd1024, 11'd5, 11'd34, 11'd32, 11'd17};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int hex_digit(input logic [CHAR_W-1:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
    if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
    return -1;
  endfunction

  function automatic bit emit_decoded(input logic [CHAR_W-1:0] v, output ssid_res_t r);
    r = '0;
    if (v == 8'h00 || count_q >= MAX_BYTES || ({5'd0, count_q} + 11'd1) >= buf_size_q) begin
      phase_q = PH_ERROR;
      return 1'b0;
    end
    count_q      = count_q + 1'b1;
    phase_q      = PH_NORMAL;
    r.out_byte   = v;
    r.byte_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit decode_char(input logic [CHAR_W-1:0] ch, input logic em,
                                     output ssid_res_t r);
    int d;
    bit ok;
    r = '0;
    if (em) begin
      ok = phase_q == PH_NORMAL && count_q != '0 && count_q <= MAX_BYTES &&
           {5'd0, count_q} < buf_size_q;
      r.done_res       = 1'b1;
      r.status         = ok ? ST_OK : ST_ERR;
      r.decoded_length = ok ? count_q : '0;
      phase_q  = PH_NORMAL;
      nibble_q = '0;
      count_q  = '0;
      return 1'b1;
    end
    case (phase_q)
      PH_NORMAL: begin
        if (ch == CH_BACKSLASH) begin
          phase_q = PH_ESC;
          return 1'b0;
        end
        return emit_decoded(ch, r);
      end
      PH_ESC: begin
        case (ch)
          CH_BACKSLASH, CH_QUOTE: return emit_decoded(ch, r);
          CH_N: return emit_decoded(BYTE_LF, r);
          CH_R: return emit_decoded(BYTE_CR, r);
          CH_T: return emit_decoded(BYTE_TAB, r);
          CH_E: return emit_decoded(BYTE_ESC, r);
          CH_X: begin
            phase_q = PH_HEX_HIGH;
            return 1'b0;
          end
          default: begin
            phase_q = PH_ERROR;
            return 1'b0;
          end
        endcase
      end
      PH_HEX_HIGH: begin
        d = hex_digit(ch);
        if (d < 0) begin
          phase_q = PH_ERROR;
        end else begin
          nibble_q = d[3:0];
          phase_q  = PH_HEX_LOW;
        end
        return 1'b0;
      end
      PH_HEX_LOW: begin
        d = hex_digit(ch);
        if (d < 0) begin
          phase_q = PH_ERROR;
          return 1'b0;
        end
        return emit_decoded({nibble_q, d[3:0]}, r);
      end
      default: return 1'b0;
    endcase
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input int v);
    if (v < 10) return "0" + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
  endfunction

  task automatic push_request(input logic [CHAR_W-1:0] ch, input logic em);
    int        gap;
    bit        has_res;
    ssid_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.in_char  <= ch;
    req_if.end_mark <= em;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    has_res = decode_char(ch, em, r);
    chk.note_request(has_res, r);
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[k]) push_request(s[k], 1'b0);
    push_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic random_string();
    char_q_t s;
    int      n;
    int      kind;
    int      v;
    if ($urandom_range(0, 29) == 0) n = 0;
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 40);
    else n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        v = $urandom_range(1, 255);
        if (8'(v) == CH_BACKSLASH) s.push_back(CH_BACKSLASH);
        s.push_back(8'(v));
      end else if (kind < 75) begin
        s.push_back(CH_BACKSLASH);
        s.push_back(esc_letters[$urandom_range(0, 5)]);
      end else if (kind < 90) begin
        v = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 255);
        s.push_back(CH_BACKSLASH);
        s.push_back(CH_X);
        s.push_back(hex_char(v >> 4));
        s.push_back(hex_char(v & 15));
      end else begin
        // noise: raw byte, escape of a random byte, hex escape with a random digit, or a lone backslash
        case ($urandom_range(0, 3))
          0: s.push_back(8'($urandom_range(0, 255)));
          1: begin
            s.push_back(CH_BACKSLASH);
            s.push_back(8'($urandom_range(0, 255)));
          end
          2: begin
            s.push_back(CH_BACKSLASH);
            s.push_back(CH_X);
            s.push_back(8'($urandom_range(0, 255)));
          end
          default: s.push_back(CH_BACKSLASH);
        endcase
      end
    end
    send_string(s);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_buf_size(input logic [BUF_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_BUFFER_SIZE));
    pwdata  <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    buf_size_q = val;
    // read back the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[BUF_W-1:0] !== val)
      chk.report($sformatf("buffer_size reads %0d, written %0d", prdata[BUF_W-1:0], val));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stalls, check every accepted result
  initial begin : result_sink
    int hold;
    hold = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready)
        chk.check_result('{res_if.out_byte, res_if.byte_valid, res_if.done_res,
                           res_if.status, res_if.decoded_length});
      if (hold == 0) hold = pick_gap();
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    char_q_t s;
    int      target;
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.in_char  <= '0;
    req_if.end_mark <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    calm       = 1'b0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // the backslash, quote and ESC escapes, a hex pair, and the top plain byte
    s = '{CH_BACKSLASH, CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE, CH_BACKSLASH, CH_E,
          CH_BACKSLASH, CH_X, "4", "F", 8'hff};
    send_string(s);
    s = '{CH_BACKSLASH, "q"};
    send_string(s);
    s = '{8'h00};
    send_string(s);
    s = '{CH_BACKSLASH, CH_X, "G"};
    send_string(s);
    s = {};
    send_string(s);
    // end arrives inside a hex escape
    s = '{CH_BACKSLASH, CH_X, "a"};
    send_string(s);
    wait_idle();

    items_sent = 0;
    foreach (buf_sizes[p]) begin
      calm = (p % 4 == 3);
      write_buf_size(buf_sizes[p]);
      target = (p + 1) * 100;
      while (items_sent < target) random_string();
      wait_idle();
    end

    if (chk.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
